// ===== hdl/assert_macros.svh =====
// assertion macros shared by the key command line parser rtl
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define KCLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define KCLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/kclp_pkg.sv =====
// package for the key command line parser: character codes, reply codes, parser phases,
// result struct, prefix characters and the hex digit decoder; no dependencies
package kclp_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);
  localparam int PREFIX_LEN    = 5;
  localparam int EUI_DIGITS    = 16;
  localparam int KEY_DIGITS    = 32;
  localparam int CNT_W         = $clog2(KEY_DIGITS + 1);

  // character codes
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_BAR = 8'h7c;
  localparam logic [7:0] CH_EQ  = 8'h3d;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_M   = 8'h4d;
  localparam logic [7:0] CH_T   = 8'h54;
  localparam logic [7:0] CH_1   = 8'h31;

  // reply codes
  localparam logic RESP_OK    = 1'b0;
  localparam logic RESP_ERROR = 1'b1;

  typedef enum logic [3:0] {
    PH_START,
    PH_PREFIX,
    PH_A,
    PH_AT,
    PH_F1,
    PH_F2,
    PH_F3,
    PH_BAD,
    PH_OTHER
  } phase_t;

  typedef struct packed {
    logic        response;
    logic        is_configured;
    logic [63:0] app_eui;
    logic [63:0] dev_eui;
    logic [63:0] app_key_high;
    logic [63:0] app_key_low;
  } res_t;

  // characters of the key command prefix "CMD1="
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = CH_C;
      3'd1:    ch = CH_M;
      3'd2:    ch = CH_D;
      3'd3:    ch = CH_1;
      3'd4:    ch = CH_EQ;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // hex digit decode: bit 4 flags a valid digit, low nibble is its value
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] d;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = {1'b1, ch[3:0]};
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      d = {1'b1, ch[3:0] + 4'd9};
    end else begin
      d = 5'b0;
    end
    return d;
  endfunction

endpackage

// ===== hdl/kclp_if.sv =====
// valid/ready channel interfaces of the key command line parser
// byte channel in and reply channel out; no dependencies
interface kclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kclp_out_if;
  logic        valid;
  logic        ready;
  logic        response;
  logic        is_configured;
  logic [63:0] app_eui;
  logic [63:0] dev_eui;
  logic [63:0] app_key_high;
  logic [63:0] app_key_low;

  modport source (output valid, output response, output is_configured, output app_eui,
                  output dev_eui, output app_key_high, output app_key_low, input ready);
  modport sink   (input valid, input response, input is_configured, input app_eui,
                  input dev_eui, input app_key_high, input app_key_low, output ready);
endinterface

// ===== hdl/kclp_inreg.sv =====
// input byte register of the key command line parser
// depends on kclp_if for the input channel
module kclp_inreg (
  input  logic       clk,
  input  logic       rst_n,
  kclp_in_if.sink    in_ch,
  input  logic       consume,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // take a new byte whenever the register is empty or being drained
  assign in_ch.ready = !valid_r || consume;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

// ===== hdl/kclp_parser.sv =====
// line parser state and key stores of the key command line parser
// depends on kclp_pkg for phases, character codes and the result struct
module kclp_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    byte_data,
  output logic          res_valid,
  output kclp_pkg::res_t res,
  output logic          configured
);
  import kclp_pkg::*;

  localparam logic [LEN_W-1:0] LEN_LAST   = LEN_W'(LINE_CAPACITY - 1);
  localparam logic [LEN_W-1:0] PREFIX_END = LEN_W'(PREFIX_LEN - 1);
  localparam logic [LEN_W-1:0] PREFIX_TOP = LEN_W'(PREFIX_LEN);
  localparam logic [CNT_W-1:0] EUI_CNT    = CNT_W'(EUI_DIGITS);
  localparam logic [CNT_W-1:0] KEY_CNT    = CNT_W'(KEY_DIGITS);

  logic             in_status_r, in_status_nxt;
  logic             after_return_r, after_return_nxt;
  logic [LEN_W-1:0] line_len_r, line_len_nxt;
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [127:0]     shadow_r, shadow_nxt;
  logic [63:0]      app_eui_r, app_eui_nxt;
  logic [63:0]      dev_eui_r, dev_eui_nxt;
  logic [127:0]     key_r, key_nxt;
  logic             cfg_r, cfg_nxt;

  logic             skip_lf;
  logic             ok;
  logic [4:0]       hex;
  logic [CNT_W-1:0] limit;
  logic             digit_ok;

  assign skip_lf  = after_return_r && (byte_data == CH_LF);
  assign hex      = hex_decode(byte_data);
  assign limit    = (phase_r == PH_F3) ? KEY_CNT : EUI_CNT;
  assign digit_ok = hex[4] && (count_r < limit);

  // next state for one received byte
  always_comb begin
    in_status_nxt    = in_status_r;
    after_return_nxt = after_return_r;
    line_len_nxt     = line_len_r;
    phase_nxt        = phase_r;
    count_nxt        = count_r;
    shadow_nxt       = shadow_r;
    app_eui_nxt      = app_eui_r;
    dev_eui_nxt      = dev_eui_r;
    key_nxt          = key_r;
    cfg_nxt          = cfg_r;
    res_valid        = 1'b0;
    ok               = 1'b0;

    if (fire) begin
      after_return_nxt = 1'b0;
      if (!skip_lf) begin
        if (byte_data == CH_PCT) begin
          in_status_nxt = !in_status_r;
        end else if (!in_status_r) begin
          if (byte_data != CH_CR) begin
            // ordinary character, kept while the line has room
            if (line_len_r < LEN_LAST) begin
              line_len_nxt = line_len_r + 1'b1;
              unique case (phase_r)
                PH_START: begin
                  if (byte_data == CH_C) begin
                    phase_nxt = PH_PREFIX;
                  end else if (byte_data == CH_A) begin
                    phase_nxt = PH_A;
                  end else begin
                    phase_nxt = PH_OTHER;
                  end
                end
                PH_PREFIX: begin
                  if (line_len_r < PREFIX_TOP && byte_data == prefix_char(line_len_r[2:0])) begin
                    if (line_len_r == PREFIX_END) begin
                      phase_nxt  = PH_F1;
                      count_nxt  = '0;
                      shadow_nxt = '0;
                    end
                  end else begin
                    phase_nxt = PH_OTHER;
                  end
                end
                PH_A: begin
                  phase_nxt = (byte_data == CH_T) ? PH_AT : PH_OTHER;
                end
                PH_AT: begin
                  phase_nxt = PH_OTHER;
                end
                PH_F1, PH_F2, PH_F3: begin
                  if (byte_data == CH_BAR && phase_r != PH_F3) begin
                    // separator closes an identifier field
                    if (count_r == EUI_CNT) begin
                      if (phase_r == PH_F1) begin
                        app_eui_nxt = shadow_r[63:0];
                        phase_nxt   = PH_F2;
                      end else begin
                        dev_eui_nxt = shadow_r[63:0];
                        phase_nxt   = PH_F3;
                      end
                      count_nxt  = '0;
                      shadow_nxt = '0;
                    end else begin
                      phase_nxt = PH_BAD;
                    end
                  end else if (digit_ok) begin
                    shadow_nxt = {shadow_r[123:0], hex[3:0]};
                    count_nxt  = count_r + 1'b1;
                  end else begin
                    phase_nxt = PH_BAD;
                  end
                end
                PH_BAD, PH_OTHER: begin
                  phase_nxt = phase_r;
                end
                default: begin
                  phase_nxt = phase_r;
                end
              endcase
            end
          end else begin
            // carriage return ends the line
            after_return_nxt = 1'b1;
            if (line_len_r != '0) begin
              if (phase_r == PH_AT) begin
                ok = 1'b1;
              end else if (phase_r == PH_F3 && count_r == KEY_CNT) begin
                key_nxt = shadow_r;
                cfg_nxt = 1'b1;
                ok      = 1'b1;
              end
              res_valid = 1'b1;
            end
            line_len_nxt = '0;
            phase_nxt    = PH_START;
            count_nxt    = '0;
            shadow_nxt   = '0;
          end
        end
      end
    end
  end

  // reply built from the updated stores
  always_comb begin
    res.response      = ok ? RESP_OK : RESP_ERROR;
    res.is_configured = cfg_nxt;
    res.app_eui       = app_eui_nxt;
    res.dev_eui       = dev_eui_nxt;
    res.app_key_high  = key_nxt[127:64];
    res.app_key_low   = key_nxt[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_status_r    <= 1'b0;
      after_return_r <= 1'b0;
      line_len_r     <= '0;
      phase_r        <= PH_START;
      count_r        <= '0;
      shadow_r       <= '0;
      app_eui_r      <= '0;
      dev_eui_r      <= '0;
      key_r          <= '0;
      cfg_r          <= 1'b0;
    end else begin
      in_status_r    <= in_status_nxt;
      after_return_r <= after_return_nxt;
      line_len_r     <= line_len_nxt;
      phase_r        <= phase_nxt;
      count_r        <= count_nxt;
      shadow_r       <= shadow_nxt;
      app_eui_r      <= app_eui_nxt;
      dev_eui_r      <= dev_eui_nxt;
      key_r          <= key_nxt;
      cfg_r          <= cfg_nxt;
    end
  end

  assign configured = cfg_r;

endmodule

// ===== hdl/kclp_outreg.sv =====
// reply output register of the key command line parser
// depends on kclp_pkg for the result struct and kclp_if for the channel
module kclp_outreg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  kclp_pkg::res_t res,
  output logic           room,
  kclp_out_if.source     out_ch
);
  import kclp_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  // slot is free when empty or when the held reply leaves this cycle
  assign room = !valid_r || out_ch.ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.response      = data_r.response;
  assign out_ch.is_configured = data_r.is_configured;
  assign out_ch.app_eui       = data_r.app_eui;
  assign out_ch.dev_eui       = data_r.dev_eui;
  assign out_ch.app_key_high  = data_r.app_key_high;
  assign out_ch.app_key_low   = data_r.app_key_low;

endmodule

// ===== hdl/key_command_line_parser_top.sv =====
// A reply is loaded into the reply register when the carriage return that ends its line is parsed.
// Throughput: one byte per cycle; the byte register and the reply register
// each hold one item, so a byte moves on every cycle the reply slot is free.
// A waiting reply stalls the parser; the byte register keeps taking one more byte meanwhile.
// Reset (synchronous, rst_n low) clears the parser state, the stored keys and the
// configured flag, and empties both registers; no clearing pass follows.
`include "assert_macros.svh"

module key_command_line_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  kclp_in_if.sink     in_ch,
  kclp_out_if.source  out_ch
);
  import kclp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       room;
  logic       fire;
  logic       res_valid;
  logic       configured;
  res_t       res;

  // a byte is parsed when present and the reply slot is free, whether or not it makes a reply
  assign fire = byte_valid && room;

  kclp_inreg u_inreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .consume    (fire),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  kclp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .byte_data  (byte_data),
    .res_valid  (res_valid),
    .res        (res),
    .configured (configured)
  );

  kclp_outreg u_outreg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (fire && res_valid),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

  // checks
  `KCLP_ASSERT(a_cfg_sticky, configured |=> configured, "configured flag dropped")
  `KCLP_ASSERT(a_reply_src, $rose(out_ch.valid) |-> $past(fire && res_valid), "stray reply")
  `KCLP_ASSERT(a_no_overwrite, (out_ch.valid && !out_ch.ready) |-> !fire, "fire under stall")
  `KCLP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_ch.valid, "reply valid right after reset")

endmodule

// ===== bench/kclp_reply_checker.sv =====
// reply checker for the key command line parser: watches the byte and reply channels,
// predicts every reply from the accepted bytes and compares it field by field
// depends on kclp_pkg (constants, phase_t, res_t) and kclp_if (channel interfaces)
module kclp_reply_checker (
  input  logic clk,
  input  logic rst_n,
  kclp_in_if   in_ch,
  kclp_out_if  out_ch,
  output int   fail_count,
  output int   reply_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import kclp_pkg::*;

  localparam logic [39:0] KEY_CMD    = "CMD1=";

  // predicted parser state
  bit          in_msg;
  bit          after_cr;
  int          line_len;
  int          digit_cnt;
  phase_t      phase;
  logic [127:0] digits;
  logic [63:0] app_eui_q;
  logic [63:0] dev_eui_q;
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  bit          configured_q;

  res_t expected_replies[$];

  // value of a hex digit, -1 for anything else
  function automatic int hex_nibble(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch) - 8'h30;
    if (ch >= "a" && ch <= "f") return int'(ch) - 8'h57;
    if (ch >= "A" && ch <= "F") return int'(ch) - 8'h37;
    return -1;
  endfunction

  function automatic void open_field(input phase_t nxt);
    phase     = nxt;
    digit_cnt = 0;
    digits    = '0;
  endfunction

  // shift one key digit in, or spoil the line
  function automatic void shift_digit(input logic [7:0] ch, input int limit);
    int nib;
    nib = hex_nibble(ch);
    if (nib < 0 || digit_cnt >= limit) begin
      phase = PH_BAD;
    end else begin
      digits    = {digits[123:0], 4'(nib)};
      digit_cnt = digit_cnt + 1;
    end
  endfunction

  // identifier field: a bar closes it, storing it when it has the full length
  function automatic void eui_char(input logic [7:0] ch, input bit slot, input phase_t nxt);
    if (ch == CH_BAR) begin
      if (digit_cnt == EUI_DIGITS) begin
        if (slot) dev_eui_q = digits[63:0];
        else app_eui_q = digits[63:0];
        open_field(nxt);
      end else begin
        phase = PH_BAD;
      end
    end else begin
      shift_digit(ch, EUI_DIGITS);
    end
  endfunction

  function automatic void parse_char(input logic [7:0] ch, input int pos);
    logic [7:0] want;
    case (phase)
      PH_START: begin
        if (ch == CH_C) phase = PH_PREFIX;
        else if (ch == CH_A) phase = PH_A;
        else phase = PH_OTHER;
      end
      PH_PREFIX: begin
        want = (pos < PREFIX_LEN) ? KEY_CMD[8*(PREFIX_LEN-1-pos) +: 8] : 8'h00;
        if (pos < PREFIX_LEN && ch == want) begin
          if (pos == PREFIX_LEN - 1) open_field(PH_F1);
        end else begin
          phase = PH_OTHER;
        end
      end
      PH_A:  phase = (ch == CH_T) ? PH_AT : PH_OTHER;
      PH_AT: phase = PH_OTHER;
      PH_F1: eui_char(ch, 1'b0, PH_F2);
      PH_F2: eui_char(ch, 1'b1, PH_F3);
      PH_F3: shift_digit(ch, KEY_DIGITS);
      default: ;
    endcase
  endfunction

  // one received byte; returns 1 when it completes a line with a reply
  function automatic bit parse_rx_byte(input logic [7:0] ch, output res_t reply);
    bit skip_lf;
    bit ok;
    skip_lf  = after_cr && ch == CH_LF;
    after_cr = 1'b0;
    reply    = '0;
    if (skip_lf) return 1'b0;
    if (ch == CH_PCT) begin
      in_msg = !in_msg;
      return 1'b0;
    end
    if (in_msg) return 1'b0;
    if (ch != CH_CR) begin
      if (line_len < LINE_CAPACITY - 1) begin
        parse_char(ch, line_len);
        line_len = line_len + 1;
      end
      return 1'b0;
    end
    // carriage return ends the line
    after_cr = 1'b1;
    if (line_len == 0) begin
      open_field(PH_START);
      return 1'b0;
    end
    ok = 1'b0;
    if (phase == PH_AT) begin
      ok = 1'b1;
    end else if (phase == PH_F3 && digit_cnt == KEY_DIGITS) begin
      key_hi_q     = digits[127:64];
      key_lo_q     = digits[63:0];
      configured_q = 1'b1;
      ok           = 1'b1;
    end
    line_len = 0;
    open_field(PH_START);
    reply.response      = ok ? RESP_OK : RESP_ERROR;
    reply.is_configured = configured_q;
    reply.app_eui       = app_eui_q;
    reply.dev_eui       = dev_eui_q;
    reply.app_key_high  = key_hi_q;
    reply.app_key_low   = key_lo_q;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // monitor: reply transaction first, then the byte transaction of the same edge
  always @(posedge clk) begin
    res_t want;
    res_t predicted;
    if (!rst_n) begin
      in_msg       = 1'b0;
      after_cr     = 1'b0;
      line_len     = 0;
      configured_q = 1'b0;
      app_eui_q    = '0;
      dev_eui_q    = '0;
      key_hi_q     = '0;
      key_lo_q     = '0;
      open_field(PH_START);
      expected_replies.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no line pending");
        end else begin
          want = expected_replies.pop_front();
          check_field("response", 64'(out_ch.response), 64'(want.response));
          check_field("is_configured", 64'(out_ch.is_configured), 64'(want.is_configured));
          check_field("app_eui", out_ch.app_eui, want.app_eui);
          check_field("dev_eui", out_ch.dev_eui, want.dev_eui);
          check_field("app_key_high", out_ch.app_key_high, want.app_key_high);
          check_field("app_key_low", out_ch.app_key_low, want.app_key_low);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (parse_rx_byte(in_ch.rx_byte, predicted)) expected_replies.push_back(predicted);
      end
    end
    reply_pending <= expected_replies.size();
  end

endmodule

// ===== bench/key_command_line_parser_top_tb.sv =====
// testbench top for the key command line parser: clock, reset, byte stimulus,
// reply-side backpressure, watchdog and verdict
// depends on kclp_pkg, kclp_if, kclp_reply_checker and key_command_line_parser_top
module key_command_line_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kclp_pkg::*;

  localparam int RANDOM_BYTES   = 1050;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_PAUSE      = 10;

  typedef enum int {KF_NONE, KF_SHORT, KF_LONG, KF_JUNK, KF_SEP, KF_TAIL, KF_PREFIX} key_fault_t;
  typedef enum int {EOL_CR, EOL_CRLF, EOL_ANY} eol_t;
  typedef enum int {KP_RANDOM, KP_EXTREME} key_pattern_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   idle_on = 1'b1;
  int   line_bytes;
  int   quiet_cycles;
  int   fail_count;
  int   reply_pending;

  kclp_in_if  in_ch();
  kclp_out_if out_ch();

  key_command_line_parser_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kclp_reply_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .reply_pending (reply_pending)
  );

  always #5 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    return (v < 10) ? 8'h30 + 8'(v) : (upper ? 8'h37 : 8'h57) + 8'(v);
  endfunction

  // a byte that is neither a hex digit nor a control character of the protocol
  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(8'h47, 8'h5a));
      1:       return 8'($urandom_range(8'h67, 8'h7a));
      2:       return 8'($urandom_range(8'h3a, 8'h40));
      3:       return 8'($urandom_range(8'h00, 8'h09));
      default: return 8'($urandom_range(8'h80, 8'hff));
    endcase
  endfunction

  // one byte transaction; valid only drops when a gap follows
  task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
    int gap;
    gap = idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (counted) line_bytes = line_bytes + 1;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // status message, dropped by the parser
  task automatic send_status();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 6);
    send_byte(CH_PCT, 1'b0);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_PCT) b = CH_CR;
      send_byte(b, 1'b0);
    end
    send_byte(CH_PCT, 1'b0);
  endtask

  task automatic finish_line(input eol_t eol);
    int r;
    send_byte(CH_CR);
    if (eol == EOL_CRLF) begin
      send_byte(CH_LF);
    end else if (eol == EOL_ANY) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        send_byte(CH_LF);
      end else if (r == 5) begin
        send_byte(CH_LF);
        send_byte(CH_LF);
      end else if (r == 6) begin
        send_byte(CH_CR);
      end
    end
  endtask

  // key command line, optionally with one fault in the prefix, in one field or after the last field
  task automatic send_key_line(input key_pattern_t pattern, input key_fault_t fault,
                               input int fault_field);
    int field_len [3];
    int n;
    int bad_pos;
    int p;
    logic [7:0] ch;
    string cmd;
    cmd          = "CMD1=";
    field_len[0] = EUI_DIGITS;
    field_len[1] = EUI_DIGITS;
    field_len[2] = KEY_DIGITS;
    p = (fault == KF_PREFIX) ? $urandom_range(0, PREFIX_LEN - 1) : -1;
    for (int i = 0; i < PREFIX_LEN; i++) send_byte((i == p) ? junk_char() : cmd[i]);
    for (int f = 0; f < 3; f++) begin
      n = field_len[f];
      if (f == fault_field && fault == KF_SHORT) n = $urandom_range(0, field_len[f] - 1);
      if (f == fault_field && fault == KF_LONG) n = field_len[f] + $urandom_range(1, 3);
      bad_pos = (f == fault_field && fault == KF_JUNK) ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        if (pattern == KP_RANDOM) ch = hex_char(4'($urandom_range(0, 15)),
                                                1'($urandom_range(0, 1)));
        else if (f == 1) ch = "F";
        else if (f == 2 && i < EUI_DIGITS) ch = "f";
        else ch = "0";
        send_byte((i == bad_pos) ? junk_char() : ch);
      end
      if (f < 2) send_byte((f == fault_field && fault == KF_SEP) ? junk_char() : CH_BAR);
    end
    if (fault == KF_TAIL) begin
      case ($urandom_range(0, 2))
        0:       send_byte(hex_char(4'($urandom_range(0, 15)), 1'b1));
        1:       send_byte(CH_BAR);
        default: send_byte(junk_char());
      endcase
    end
  endtask

  // line up to or past the capacity; a status message with a CR may sit in the dropped part
  task automatic send_long_line(input int n, input bit with_status);
    send_text("AT");
    for (int i = 2; i < n; i++) begin
      if (i == LINE_CAPACITY && with_status) begin
        send_byte(CH_PCT, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_PCT, 1'b0);
      end
      send_byte(8'($urandom_range(8'h61, 8'h7a)));
    end
  endtask

  // reply-side backpressure
  initial begin : ready_gen
    int hold;
    out_ch.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!idle_on || $urandom_range(0, 99) < 65) begin
        out_ch.ready <= 1'b1;
        hold = $urandom_range(0, 8);
      end else begin
        out_ch.ready <= 1'b0;
        hold = idle_len();
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    int kind;
    int n;
    string cmd;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    line_bytes    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines
    send_text("AT");
    finish_line(EOL_CR);
    finish_line(EOL_CR);
    send_text("AT");
    finish_line(EOL_CRLF);
    send_byte(CH_LF);
    send_text("AT");
    finish_line(EOL_CR);
    send_text("AT");
    send_byte(8'h00);
    finish_line(EOL_CR);
    send_byte(8'hff);
    finish_line(EOL_CR);
    send_byte(CH_PCT, 1'b0);
    send_text("AT");
    send_byte(CH_CR, 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_text("AT");
    finish_line(EOL_CR);
    send_text("A");
    send_status();
    send_text("T");
    finish_line(EOL_CRLF);
    send_key_line(KP_EXTREME, KF_NONE, 0);
    finish_line(EOL_CRLF);
    send_key_line(KP_RANDOM, KF_SHORT, 1);
    finish_line(EOL_CR);
    send_long_line(LINE_CAPACITY + 4, 1'b1);
    finish_line(EOL_CR);
    send_text("CMD1=");
    finish_line(EOL_CR);

    // random lines of many kinds, key commands the most common, until the byte budget is used
    cmd        = "CMD1=";
    while (line_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        send_key_line(KP_RANDOM,
                      $urandom_range(0, 1) ? KF_NONE : key_fault_t'($urandom_range(1, 6)),
                      $urandom_range(0, 2));
        finish_line(EOL_ANY);
      end else if (kind < 55) begin
        case ($urandom_range(0, 5))
          0, 1:    send_text("AT");
          2:       send_text("at");
          3:       send_text("A");
          4:       send_text("ATT");
          default: begin
            send_text("AT");
            send_byte(junk_char());
          end
        endcase
        finish_line(EOL_ANY);
      end else if (kind < 70) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          logic [7:0] b;
          b = 8'($urandom_range(0, 255));
          send_byte((b == CH_PCT) ? 8'h78 : b);
        end
        finish_line(EOL_ANY);
      end else if (kind < 80) begin
        send_status();
      end else if (kind < 86) begin
        send_text("A");
        send_status();
        send_text("T");
        finish_line(EOL_ANY);
      end else if (kind < 96) begin
        n = $urandom_range(1, PREFIX_LEN);
        for (int i = 0; i < n; i++) send_byte(cmd[i]);
        if ($urandom_range(0, 1)) send_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
        finish_line(EOL_ANY);
      end else begin
        send_long_line($urandom_range(LINE_CAPACITY - 8, LINE_CAPACITY + 12),
                       1'($urandom_range(0, 1)));
        finish_line(EOL_ANY);
      end
    end

    // drain the pending replies
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reply_pending != 0) @(posedge clk);
    repeat (END_PAUSE) @(posedge clk);

    if (fail_count == 0 && reply_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
